// ----- hw/rtl/atp_pkg.sv -----
package atp_pkg;

  // register defaults and limits
  localparam logic [5:0] BaseReset       = 6'd10;
  localparam logic [5:0] BaseMax         = 6'd36;
  localparam logic [5:0] BaseDecimal     = 6'd10;
  localparam logic [5:0] BaseOctal       = 6'd8;
  localparam logic [5:0] BaseHex         = 6'd16;
  localparam logic [5:0] BaseAuto        = 6'd0;
  localparam int         PosBitsDefault  = 16;
  localparam int         StopIndexBits   = 16;
  localparam int         CfgAddrBits     = 3;

  // register byte addresses
  localparam logic [CfgAddrBits-1:0] AddrNumberBase = 3'd0;

  // character codes
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharLowerX = 8'h78;
  localparam logic [7:0] CharUpperX = 8'h58;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7a;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] LowerOffset = 8'd87;  // 'a' - 10
  localparam logic [7:0] UpperOffset = 8'd55;  // 'A' - 10

  // parse phases
  typedef enum logic [5:0] {
    PH_SPACE    = 6'b000001,
    PH_SIGNED   = 6'b000010,
    PH_ZERO     = 6'b000100,
    PH_HEXSTART = 6'b001000,
    PH_DIGITS   = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_t;

  // digit lookup result
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } digit_t;

  // end-of-string snapshot handed from the parser to the result stage
  typedef struct packed {
    logic                     minus;
    logic [63:0]              sum;
    logic                     seen;
    logic                     ovf;
    logic [StopIndexBits-1:0] stop;
  } fin_t;

  function automatic digit_t digit_value(input logic [7:0] c);
    digit_t     d;
    logic [7:0] t;
    d = '0;
    t = '0;
    if (c >= CharZero && c <= CharNine) begin
      t = c - CharZero;
      d.ok = 1'b1;
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      t = c - LowerOffset;
      d.ok = 1'b1;
    end else if (c >= CharUpperA && c <= CharUpperZ) begin
      t = c - UpperOffset;
      d.ok = 1'b1;
    end
    d.val = t[5:0];
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

endpackage

// ----- hw/rtl/atp_ifs.sv -----
// byte stream channel
interface atp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// parse result channel
interface atp_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] parsed_value;
  logic [15:0] stop_index;
  logic        overflow_flag;
  logic        any_converted;

  modport source (output valid, output parsed_value, output stop_index,
                  output overflow_flag, output any_converted, input ready);
  modport sink   (input valid, input parsed_value, input stop_index,
                  input overflow_flag, input any_converted, output ready);
endinterface

// ----- hw/rtl/atp_cfg.sv -----
module atp_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [atp_pkg::CfgAddrBits-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [5:0]                        number_base
);

  logic sel_base;

  assign pready   = 1'b1;
  assign sel_base = (paddr == atp_pkg::AddrNumberBase);

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= atp_pkg::BaseReset;
    end else if (psel && penable && pwrite && sel_base) begin
      number_base <= pwdata[5:0];
    end
  end

  // read mux
  assign prdata = sel_base ? {26'd0, number_base} : 32'd0;

endmodule

// ----- hw/rtl/atp_core.sv -----
module atp_core #(
  parameter int POSITION_BITS = atp_pkg::PosBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  atp_char_if.sink            chars,
  input  logic [5:0]          number_base,
  input  logic                out_busy,
  output logic                fin_valid,
  output atp_pkg::fin_t       fin
);

  localparam int ExtW = (POSITION_BITS > atp_pkg::StopIndexBits) ?
                        POSITION_BITS : atp_pkg::StopIndexBits;

  // input register
  logic       in_valid;
  logic [7:0] char_q;

  // parse state
  atp_pkg::phase_t          phase, phase_next;
  logic                     is_minus, is_minus_next;
  logic [5:0]               active_base, active_base_next;
  logic [63:0]              running_sum, running_sum_next;
  logic                     digit_seen, digit_seen_next;
  logic [POSITION_BITS-1:0] char_position, char_position_next;
  logic [POSITION_BITS-1:0] stop_position, stop_position_next;
  logic                     overflowed, overflowed_next;

  logic                     term, advance;
  logic [POSITION_BITS-1:0] pos_inc;
  atp_pkg::digit_t          dig;
  logic [5:0]               take_base;
  logic                     take_ok;
  logic [69:0]              product;
  logic                     prod_ovf;
  logic [ExtW-1:0]          stop_ext;

  assign term    = (char_q == atp_pkg::CharNul);
  assign advance = in_valid && !(term && out_busy);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      char_q <= chars.char_code;
    end
  end

  // saturating position increment
  assign pos_inc = (char_position == '1) ? char_position : char_position + 1'b1;

  // base used if this byte is taken as a digit
  always_comb begin
    take_base = active_base;
    unique case (phase)
      atp_pkg::PH_SPACE, atp_pkg::PH_SIGNED:
        take_base = (number_base == atp_pkg::BaseAuto) ? atp_pkg::BaseDecimal : number_base;
      atp_pkg::PH_ZERO:
        take_base = (active_base == atp_pkg::BaseAuto) ? atp_pkg::BaseOctal : atp_pkg::BaseHex;
      default:
        take_base = active_base;
    endcase
  end

  // digit check and multiply-add with exact overflow
  assign dig      = atp_pkg::digit_value(char_q);
  assign take_ok  = (take_base != 6'd0) && (take_base <= atp_pkg::BaseMax) &&
                    dig.ok && (dig.val < take_base);
  assign product  = {6'd0, running_sum} * {64'd0, take_base} + {64'd0, dig.val};
  assign prod_ovf = (product[69:64] != 6'd0);

  // next state for one byte
  always_comb begin
    logic first, take;
    first = 1'b0;
    take  = 1'b0;
    phase_next         = phase;
    is_minus_next      = is_minus;
    active_base_next   = active_base;
    running_sum_next   = running_sum;
    digit_seen_next    = digit_seen;
    stop_position_next = stop_position;
    overflowed_next    = overflowed;
    char_position_next = pos_inc;

    unique case (phase)
      atp_pkg::PH_SPACE: begin
        if (atp_pkg::is_space(char_q)) begin
          phase_next = atp_pkg::PH_SPACE;
        end else if (char_q == atp_pkg::CharMinus) begin
          is_minus_next = 1'b1;
          phase_next    = atp_pkg::PH_SIGNED;
        end else if (char_q == atp_pkg::CharPlus) begin
          phase_next = atp_pkg::PH_SIGNED;
        end else begin
          first = 1'b1;
        end
      end
      atp_pkg::PH_SIGNED: first = 1'b1;
      atp_pkg::PH_ZERO: begin
        if (char_q == atp_pkg::CharLowerX || char_q == atp_pkg::CharUpperX) begin
          active_base_next = atp_pkg::BaseHex;
          phase_next       = atp_pkg::PH_HEXSTART;
        end else begin
          active_base_next = take_base;
          take = 1'b1;
        end
      end
      atp_pkg::PH_HEXSTART, atp_pkg::PH_DIGITS: take = 1'b1;
      default: phase_next = atp_pkg::PH_DONE;
    endcase

    // first byte after whitespace and sign
    if (first) begin
      if ((number_base == atp_pkg::BaseAuto || number_base == atp_pkg::BaseHex) &&
          char_q == atp_pkg::CharZero) begin
        active_base_next   = number_base;
        digit_seen_next    = 1'b1;
        running_sum_next   = '0;
        stop_position_next = pos_inc;
        phase_next         = atp_pkg::PH_ZERO;
      end else begin
        active_base_next = take_base;
        take = 1'b1;
      end
    end

    // digit accumulation
    if (take) begin
      if (!take_ok) begin
        phase_next = atp_pkg::PH_DONE;
      end else if (prod_ovf) begin
        overflowed_next = 1'b1;
        digit_seen_next = 1'b1;
        phase_next      = atp_pkg::PH_DONE;
      end else begin
        running_sum_next   = product[63:0];
        digit_seen_next    = 1'b1;
        stop_position_next = pos_inc;
        phase_next         = atp_pkg::PH_DIGITS;
      end
    end
  end

  // state registers, cleared after each terminating byte
  always_ff @(posedge clk) begin
    if (rst || (advance && term)) begin
      phase         <= atp_pkg::PH_SPACE;
      is_minus      <= 1'b0;
      active_base   <= 6'd0;
      running_sum   <= '0;
      digit_seen    <= 1'b0;
      char_position <= '0;
      stop_position <= '0;
      overflowed    <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      is_minus      <= is_minus_next;
      active_base   <= active_base_next;
      running_sum   <= running_sum_next;
      digit_seen    <= digit_seen_next;
      char_position <= char_position_next;
      stop_position <= stop_position_next;
      overflowed    <= overflowed_next;
    end
  end

  // snapshot on the terminating byte
  assign stop_ext  = ExtW'(stop_position);
  assign fin_valid = advance && term;
  assign fin.minus = is_minus;
  assign fin.sum   = running_sum;
  assign fin.seen  = digit_seen;
  assign fin.ovf   = overflowed;
  assign fin.stop  = (stop_ext > ExtW'(16'hffff)) ? 16'hffff :
                     stop_ext[atp_pkg::StopIndexBits-1:0];

endmodule

// ----- hw/rtl/atp_result.sv -----
module atp_result (
  input  logic           clk,
  input  logic           rst,
  input  logic           fin_valid,
  input  atp_pkg::fin_t  fin,
  output logic           out_busy,
  atp_result_if.source   results
);

  logic [63:0] value_next;
  logic [15:0] stop_next;

  // final value selection
  always_comb begin
    value_next = '0;
    stop_next  = '0;
    if (fin.ovf) begin
      value_next = '1;
    end else if (fin.seen) begin
      value_next = fin.minus ? (~fin.sum + 64'd1) : fin.sum;
      stop_next  = fin.stop;
    end
  end

  assign out_busy = results.valid && !results.ready;

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fin_valid) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (fin_valid) begin
      results.parsed_value  <= value_next;
      results.stop_index    <= stop_next;
      results.overflow_flag <= fin.ovf;
      results.any_converted <= fin.seen;
    end
  end

endmodule

// ----- hw/rtl/ascii_to_u64_parser.sv -----
// channel   dir  payload                                           transaction
// chars     in   char_code[7:0]                                    valid && ready
// results   out  parsed_value[63:0] stop_index[15:0] overflow_flag valid && ready
//                any_converted
// cfg       in   apb, number_base at byte 0                        psel && penable
//
// one byte per cycle sustained except while chars stalls: input register, then digit check
// and one 64x6 multiply-add, combinational, into the parse state registers
// a zero byte in the input register loads the result register unless that is still full
// synchronous reset sets number_base to 10 and clears the parse state
// chars stalls only when a zero byte meets a result register still full
module ascii_to_u64_parser #(
  parameter int POSITION_BITS = atp_pkg::PosBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  atp_char_if.sink                        chars,
  atp_result_if.source                    results,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [atp_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic          [5:0] number_base;
  logic                out_busy;
  logic                fin_valid;
  atp_pkg::fin_t       fin;

  // configuration register
  atp_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .number_base (number_base)
  );

  // per-byte parser
  atp_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars),
    .number_base (number_base),
    .out_busy    (out_busy),
    .fin_valid   (fin_valid),
    .fin         (fin)
  );

  // result register
  atp_result u_result (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin       (fin),
    .out_busy  (out_busy),
    .results   (results)
  );

endmodule
